>>> sv/fhs_pkg.sv
// shared types and constants for the fifo queue with heap sort
package fhs_pkg;

	localparam int FHS_DEPTH  = 64;
	localparam int FHS_DATA_W = 32;

	typedef enum logic [1:0] {
		ACT_ENQ  = 2'd0,
		ACT_DEQ  = 2'd1,
		ACT_SORT = 2'd2
	} fhs_action_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} fhs_status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_BLD_RD,
		S_BLD_CUR,
		S_SIFT_RL,
		S_SIFT_RR,
		S_SIFT_CMP,
		S_EXT_RK,
		S_EXT_RZ,
		S_EXT_WK
	} fhs_seq_state_t;

	typedef enum logic [1:0] {
		PICK_SELF  = 2'd0,
		PICK_LEFT  = 2'd1,
		PICK_RIGHT = 2'd2
	} fhs_pick_t;

	typedef struct packed {
		logic rd_en;
		logic wr_en;
		logic done;
		logic busy;
	} fhs_seq_ctl_t;

endpackage

>>> sv/fifo_queue_with_heap_sort_unit.sv
// top level: ring-buffer fifo of signed words with an in-place heap sort command
//
// usage
//   command channel: start/busy. a word (action, push_value) is taken at a rising
//   edge with start high and busy low. action: enqueue, dequeue, sort ascending.
//   result channel: done strobes for exactly one cycle with pop_value, status and
//   occupancy; the receiver has no way to stall it and must take it then.
// latency and throughput
//   enqueue, dequeue and an unused action code: result in the cycle after the word
//   is taken, busy stays low, so a new word can follow in every cycle.
//   sort with n > 1 stored words: busy until the sort is through; the single read
//   port of the store sets the pace, each heap step needs one read per child and
//   one write. the result comes in the same cycle that busy drops. sort with one
//   word or none answers in the cycle after it is taken, with busy low.
// reset
//   arst_n clears head and count (empty queue) and idles the sequencer; the store
//   itself is not cleared, an entry is only read after it was written.
// full / empty
//   enqueue on a full queue drops the word (status full); dequeue on an empty
//   queue returns all ones (status empty).
module fifo_queue_with_heap_sort_unit #(
	parameter int DEPTH = fhs_pkg::FHS_DEPTH
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [1:0]                           action,
	input  logic signed [fhs_pkg::FHS_DATA_W-1:0] push_value,
	output logic                                 done,
	output logic signed [fhs_pkg::FHS_DATA_W-1:0] pop_value,
	output logic [1:0]                           status,
	output logic [$clog2(DEPTH+1)-1:0]           occupancy
);
	import fhs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int SW = CW + 1;

	typedef enum logic [1:0] {
		POP_ZERO,
		POP_ONES,
		POP_RAM
	} pop_sel_t;

	// ring position of base + offset, offset never above the depth
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
	                                           input logic [CW-1:0] offs);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(offs);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	logic [AW-1:0]         head_q;
	logic [CW-1:0]         count_q;
	logic                  done_q;
	fhs_status_t           status_q;
	pop_sel_t              pop_sel_q;

	logic                  accept;
	fhs_action_t           act;
	logic                  is_full, is_empty;
	logic                  sort_go;

	fhs_seq_ctl_t          seq_ctl;
	logic [AW-1:0]         seq_rd_idx, seq_wr_idx;
	logic [FHS_DATA_W-1:0] seq_wr_data;

	logic                  ram_we, ram_re;
	logic [AW-1:0]         ram_waddr, ram_raddr;
	logic [FHS_DATA_W-1:0] ram_wdata, ram_rdata;

	assign busy     = seq_ctl.busy;
	assign accept   = start && !busy;
	assign act      = fhs_action_t'(action);
	assign is_full  = (count_q == CW'(DEPTH));
	assign is_empty = (count_q == '0);
	assign sort_go  = accept && act == ACT_SORT && count_q > CW'(1);

	// store ports: sequencer owns them during a sort, commands otherwise
	always_comb begin
		if (seq_ctl.busy) begin
			ram_we    = seq_ctl.wr_en;
			ram_waddr = wrap_add(head_q, CW'(seq_wr_idx));
			ram_wdata = seq_wr_data;
			ram_re    = seq_ctl.rd_en;
			ram_raddr = wrap_add(head_q, CW'(seq_rd_idx));
		end else begin
			ram_we    = accept && act == ACT_ENQ && !is_full;
			ram_waddr = wrap_add(head_q, count_q);
			ram_wdata = push_value;
			ram_re    = accept && act == ACT_DEQ && !is_empty;
			ram_raddr = head_q;
		end
	end

	fhs_ram #(
		.WIDTH (FHS_DATA_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fhs_heap_seq #(
		.DEPTH (DEPTH)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (sort_go),
		.n       (count_q),
		.rdata   (ram_rdata),
		.ctl     (seq_ctl),
		.rd_idx  (seq_rd_idx),
		.wr_idx  (seq_wr_idx),
		.wr_data (seq_wr_data)
	);

	// queue pointers and the result word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q    <= '0;
			count_q   <= '0;
			done_q    <= 1'b0;
			status_q  <= ST_OK;
			pop_sel_q <= POP_ZERO;
		end else begin
			// one strobe per command; a sort hands its strobe over to the sequencer
			done_q <= (accept && !sort_go) || seq_ctl.done;
			if (seq_ctl.done) begin
				status_q  <= ST_OK;
				pop_sel_q <= POP_ZERO;
			end
			if (accept) begin
				status_q  <= ST_OK;
				pop_sel_q <= POP_ZERO;
				unique case (act)
					ACT_ENQ: begin
						if (is_full) begin
							status_q <= ST_FULL;
						end else begin
							count_q <= count_q + CW'(1);
						end
					end
					ACT_DEQ: begin
						if (is_empty) begin
							status_q  <= ST_EMPTY;
							pop_sel_q <= POP_ONES;
						end else begin
							pop_sel_q <= POP_RAM;
							head_q    <= wrap_add(head_q, CW'(1));
							count_q   <= count_q - CW'(1);
						end
					end
					default: begin
						// sort and the unused code leave the pointers alone
					end
				endcase
			end
		end
	end

	// dequeued word comes straight from the registered store read
	always_comb begin
		unique case (pop_sel_q)
			POP_RAM:  pop_value = ram_rdata;
			POP_ONES: pop_value = '1;
			default:  pop_value = '0;
		endcase
	end

	assign done      = done_q;
	assign status    = status_q;
	assign occupancy = count_q;

endmodule

>>> sv/fhs_ram.sv
// generic single-write single-read ram with registered read data
module fhs_ram #(
	parameter int WIDTH = fhs_pkg::FHS_DATA_W,
	parameter int DEPTH = fhs_pkg::FHS_DEPTH
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/fhs_heap_seq.sv
// heap sort sequencer driving one memory port pair and one shared signed comparator
module fhs_heap_seq #(
	parameter int DEPTH = fhs_pkg::FHS_DEPTH
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                go,
	input  logic [$clog2(DEPTH+1)-1:0]          n,
	input  logic [fhs_pkg::FHS_DATA_W-1:0]      rdata,
	output fhs_pkg::fhs_seq_ctl_t               ctl,
	output logic [$clog2(DEPTH)-1:0]            rd_idx,
	output logic [$clog2(DEPTH)-1:0]            wr_idx,
	output logic [fhs_pkg::FHS_DATA_W-1:0]      wr_data
);
	import fhs_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int LW = AW + 2;

	fhs_seq_state_t        state_q, state_d;
	logic [AW-1:0]         i_q;
	logic [AW-1:0]         k_q;
	logic [CW-1:0]         m_q;
	logic                  build_q;
	logic [FHS_DATA_W-1:0] cur_q;
	logic [FHS_DATA_W-1:0] bigv_q;
	fhs_pick_t             bigsel_q;

	logic [LW-1:0]         l_w, r_w, m_ext;
	logic                  l_ok, r_ok;
	logic [FHS_DATA_W-1:0] cmp_b;
	logic                  gt;
	fhs_pick_t             pick;
	logic                  sift_end;
	logic                  last_k;
	logic [CW-1:0]         n_half;

	// child positions of the current node
	assign l_w   = {1'b0, i_q, 1'b1};
	assign r_w   = l_w + LW'(1);
	assign m_ext = LW'(m_q);
	assign l_ok  = l_w < m_ext;
	assign r_ok  = r_w < m_ext;

	// the one comparator: left child against the sifted word, then right against the winner
	assign cmp_b = (state_q == S_SIFT_RR) ? cur_q : bigv_q;
	assign gt    = $signed(rdata) > $signed(cmp_b);

	assign pick     = (r_ok && gt) ? PICK_RIGHT : bigsel_q;
	assign sift_end = (state_q == S_SIFT_RL && !l_ok) ||
	                  (state_q == S_SIFT_CMP && pick == PICK_SELF);
	assign last_k   = !build_q && (k_q == AW'(1));
	assign n_half   = n >> 1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (go) state_d = S_BLD_RD;
			S_BLD_RD:   state_d = S_BLD_CUR;
			S_BLD_CUR:  state_d = S_SIFT_RL;
			S_SIFT_RL:  state_d = l_ok ? S_SIFT_RR : S_IDLE;
			S_SIFT_RR:  state_d = S_SIFT_CMP;
			S_SIFT_CMP: state_d = (pick == PICK_SELF) ? S_IDLE : S_SIFT_RL;
			S_EXT_RK:   state_d = S_EXT_RZ;
			S_EXT_RZ:   state_d = S_EXT_WK;
			S_EXT_WK:   state_d = S_SIFT_RL;
			default:    state_d = S_IDLE;
		endcase
		// end of one sift: pick the next root, the next extraction or, after the last, idle
		if (sift_end) begin
			priority if (build_q && k_q != '0) begin
				state_d = S_BLD_RD;
			end else if (build_q) begin
				state_d = S_EXT_RK;
			end else if (last_k) begin
				state_d = S_IDLE;
			end else begin
				state_d = S_EXT_RK;
			end
		end
	end

	always_comb begin
		ctl      = '0;
		ctl.busy = (state_q != S_IDLE);
		ctl.done = sift_end && last_k;
		rd_idx   = '0;
		wr_idx   = i_q;
		wr_data  = cur_q;
		unique case (state_q)
			S_BLD_RD: begin
				ctl.rd_en = 1'b1;
				rd_idx    = k_q;
			end
			S_SIFT_RL: begin
				if (l_ok) begin
					ctl.rd_en = 1'b1;
					rd_idx    = l_w[AW-1:0];
				end else begin
					ctl.wr_en = 1'b1;
				end
			end
			S_SIFT_RR: begin
				ctl.rd_en = r_ok;
				rd_idx    = r_w[AW-1:0];
			end
			S_SIFT_CMP: begin
				ctl.wr_en = 1'b1;
				unique case (pick)
					PICK_RIGHT: wr_data = rdata;
					PICK_LEFT:  wr_data = bigv_q;
					default:    wr_data = cur_q;
				endcase
			end
			S_EXT_RK: begin
				ctl.rd_en = 1'b1;
				rd_idx    = k_q;
			end
			S_EXT_RZ: begin
				ctl.rd_en = 1'b1;
				rd_idx    = '0;
			end
			S_EXT_WK: begin
				ctl.wr_en = 1'b1;
				wr_idx    = k_q;
				wr_data   = rdata;
			end
			default: begin
				ctl.rd_en = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			build_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_IDLE && go) begin
				build_q <= 1'b1;
			end else if (sift_end && build_q && k_q == '0) begin
				build_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (go) begin
					m_q <= n;
					k_q <= n_half[AW-1:0] - AW'(1);
				end
			end
			S_BLD_RD:  i_q   <= k_q;
			S_BLD_CUR: cur_q <= rdata;
			S_SIFT_RR: begin
				bigv_q   <= gt ? rdata : cur_q;
				bigsel_q <= gt ? PICK_LEFT : PICK_SELF;
			end
			S_SIFT_CMP: begin
				if (pick == PICK_RIGHT) begin
					i_q <= r_w[AW-1:0];
				end else if (pick == PICK_LEFT) begin
					i_q <= l_w[AW-1:0];
				end
			end
			S_EXT_RZ: cur_q <= rdata;
			S_EXT_WK: begin
				i_q <= '0;
				m_q <= CW'(k_q);
			end
			default: begin
			end
		endcase
		if (sift_end) begin
			if (build_q && k_q == '0) begin
				k_q <= m_q[AW-1:0] - AW'(1);
			end else begin
				k_q <= k_q - AW'(1);
			end
		end
	end

endmodule

>>> sv/fhs_check.sv
// port-level checker for the fifo queue with heap sort, bound to the top level
module fhs_check #(
	parameter int DEPTH = fhs_pkg::FHS_DEPTH
) (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic [1:0]                           action,
	input logic signed [fhs_pkg::FHS_DATA_W-1:0] push_value,
	input logic                                 done,
	input logic signed [fhs_pkg::FHS_DATA_W-1:0] pop_value,
	input logic [1:0]                           status,
	input logic [$clog2(DEPTH+1)-1:0]           occupancy
);
	import fhs_pkg::*;

	localparam int CW = $clog2(DEPTH + 1);

	// every command but sort answers in the next cycle
	a_quick_answer: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action != ACT_SORT |=> done)
		else $error("no result after a queue command");

	// a sort in progress never shows a result
	a_no_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !done)
		else $error("result while busy");

	// empty status only with an empty queue and the all-ones word
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_EMPTY |-> pop_value == -1 && occupancy == '0)
		else $error("bad empty result");

	// full status only with a full queue
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_FULL |-> occupancy == CW'(DEPTH) && pop_value == '0)
		else $error("bad full result");

	// occupancy never passes the depth
	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> occupancy <= CW'(DEPTH))
		else $error("occupancy beyond depth");

	// push_value is not watched here
	logic unused_push;
	assign unused_push = ^push_value;

endmodule

bind fifo_queue_with_heap_sort_unit fhs_check #(.DEPTH(DEPTH)) u_check (.*);
